>>> hdl/mahs_pkg.sv
// Shared types, constants and helpers of the MPEG audio header synchronizer.
`timescale 1ns / 1ps
package mahs_pkg;

  // Sync pattern and header field codes.
  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE    = 4'hF;
  localparam logic [3:0] BITRATE_FREE_BAD = 4'hF;
  localparam logic [1:0] RATE_RESERVED  = 2'd3;

  // Depth of the header queue between the parser and the result side.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Width of the lock key.
  localparam int KEY_W = 9;

  // The 20 header bits after the sync bits, MSB first.
  typedef struct packed {
    logic       version_bit;
    logic [1:0] layer_code;
    logic       no_crc;
    logic [3:0] bitrate_index;
    logic [1:0] rate_index;
    logic       padding_bit;
    logic       private_bit;
    logic [1:0] channel_mode;
    logic [1:0] mode_extension;
    logic       copyright_bit;
    logic       original_bit;
    logic [1:0] emphasis;
  } hdr_t;

  // One header word moving from the parser into the queue.
  typedef struct packed {
    logic valid;
    hdr_t hdr;
  } hdr_word_t;

  // Receive phases of the parser.
  typedef enum logic [5:0] {
    PH_HUNT_FF = 6'b000001,
    PH_HUNT_F  = 6'b000010,
    PH_HDR1    = 6'b000100,
    PH_HDR2    = 6'b001000,
    PH_CRC1    = 6'b010000,
    PH_CRC2    = 6'b100000
  } phase_t;

  // Fields that must stay the same from header to header once locked.
  function automatic logic [KEY_W-1:0] lock_key(input hdr_t h);
    lock_key = {h.version_bit, h.layer_code, h.no_crc, h.rate_index,
                h.channel_mode, h.original_bit};
  endfunction

endpackage

>>> hdl/mpeg_audio_header_sync.sv
// Top level of the MPEG audio frame header synchronizer.
`timescale 1ns / 1ps
// Takes one stream byte per cycle, finds the 0xFF / 0xFx sync pattern, gathers the
// 20 header bits, drops headers with bitrate index 15, sample-rate index 3 or fields
// that differ from the first good header, skips the two CRC bytes when protection
// is on, and delivers one word of header fields per accepted header. A byte is
// taken every cycle while full is low; the parser reaches a decision within the
// cycle a byte arrives, and a finished header is readable on the next cycle.
// Results wait in a four-word queue, and full rises only while that queue is
// full, so the byte side keeps running while the reader pauses, until it fills.
module mpeg_audio_header_sync import mahs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic       version_bit,
  output logic [1:0] layer_code,
  output logic       no_crc,
  output logic [3:0] bitrate_index,
  output logic [1:0] rate_index,
  output logic       padding_bit,
  output logic       private_bit,
  output logic [1:0] channel_mode,
  output logic [1:0] mode_extension,
  output logic       copyright_bit,
  output logic       original_bit,
  output logic [1:0] emphasis
);

  hdr_word_t enq;
  hdr_t      head;
  logic      q_full;
  logic      q_empty;

  mahs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (push && !q_full),
    .byte_data  (data_byte),
    .enq        (enq)
  );

  mahs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .deq      (pop),
    .head     (head),
    .is_empty (q_empty),
    .is_full  (q_full)
  );

  assign full  = q_full;
  assign empty = q_empty;

  // Unpack the oldest header onto the result ports.
  assign version_bit    = head.version_bit;
  assign layer_code     = head.layer_code;
  assign no_crc         = head.no_crc;
  assign bitrate_index  = head.bitrate_index;
  assign rate_index     = head.rate_index;
  assign padding_bit    = head.padding_bit;
  assign private_bit    = head.private_bit;
  assign channel_mode   = head.channel_mode;
  assign mode_extension = head.mode_extension;
  assign copyright_bit  = head.copyright_bit;
  assign original_bit   = head.original_bit;
  assign emphasis       = head.emphasis;

endmodule

>>> hdl/mahs_front.sv
// Byte parser: sync hunt, header gathering, validity and lock checks, CRC skip.
`timescale 1ns / 1ps
module mahs_front import mahs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  input  logic [7:0] byte_data,
  output hdr_word_t enq
);

  phase_t            phase;
  phase_t            phase_next;
  logic [19:0]       header_bits;
  logic [19:0]       header_bits_next;
  logic              lock_valid;
  logic              lock_valid_next;
  logic [KEY_W-1:0]  locked_fields;
  logic [KEY_W-1:0]  locked_fields_next;
  logic [19:0]       full_hdr;
  hdr_t              cand;
  logic              cand_bad;
  logic              cand_mismatch;

  // The header as it stands once its last byte arrives.
  assign full_hdr      = {header_bits[11:0], byte_data};
  assign cand          = hdr_t'(full_hdr);
  assign cand_bad      = (cand.bitrate_index == BITRATE_FREE_BAD) ||
                         (cand.rate_index == RATE_RESERVED);
  assign cand_mismatch = lock_valid && (lock_key(cand) != locked_fields);

  // Phase update for each accepted byte.
  always_comb begin
    phase_next         = phase;
    header_bits_next   = header_bits;
    lock_valid_next    = lock_valid;
    locked_fields_next = locked_fields;
    enq.valid          = 1'b0;
    enq.hdr            = hdr_t'(header_bits);
    if (byte_valid) begin
      case (phase)
        PH_HUNT_FF: begin
          phase_next = (byte_data == SYNC_BYTE) ? PH_HUNT_F : PH_HUNT_FF;
        end
        PH_HUNT_F: begin
          if (byte_data[7:4] == SYNC_NIBBLE) begin
            header_bits_next = {16'd0, byte_data[3:0]};
            phase_next       = PH_HDR1;
          end else begin
            phase_next = PH_HUNT_FF;
          end
        end
        PH_HDR1: begin
          header_bits_next = full_hdr;
          phase_next       = PH_HDR2;
        end
        PH_HDR2: begin
          header_bits_next = full_hdr;
          phase_next       = PH_HUNT_FF;
          if (!cand_bad && !cand_mismatch) begin
            if (!lock_valid) begin
              lock_valid_next    = 1'b1;
              locked_fields_next = lock_key(cand);
            end
            if (!cand.no_crc) begin
              phase_next = PH_CRC1;
            end else begin
              enq.valid = 1'b1;
              enq.hdr   = cand;
            end
          end
        end
        PH_CRC1: begin
          phase_next = PH_CRC2;
        end
        PH_CRC2: begin
          phase_next = PH_HUNT_FF;
          enq.valid  = 1'b1;
        end
        default: begin
          phase_next = PH_HUNT_FF;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT_FF;
      header_bits   <= '0;
      lock_valid    <= 1'b0;
      locked_fields <= '0;
    end else begin
      phase         <= phase_next;
      header_bits   <= header_bits_next;
      lock_valid    <= lock_valid_next;
      locked_fields <= locked_fields_next;
    end
  end

  // Every emitted header is valid and matches the lock.
  a_enq_matches_lock: assert property (@(posedge clk) disable iff (rst)
    enq.valid |-> lock_valid_next && (lock_key(enq.hdr) == locked_fields_next))
    else $error("emitted header does not match the lock");

  a_enq_fields_legal: assert property (@(posedge clk) disable iff (rst)
    enq.valid |-> (enq.hdr.bitrate_index != BITRATE_FREE_BAD) &&
                  (enq.hdr.rate_index != RATE_RESERVED))
    else $error("emitted header carries a reserved index");

  a_lock_holds: assert property (@(posedge clk) disable iff (rst)
    lock_valid |=> lock_valid && $stable(locked_fields))
    else $error("lock changed after it was taken");

  // The second CRC phase is entered from the first and may wait there while idle.
  a_crc_word_only_after_crc1: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CRC2) |-> ($past(phase) == PH_CRC1) || ($past(phase) == PH_CRC2))
    else $error("second CRC word reached without the first");

endmodule

>>> hdl/mahs_queue.sv
// Short header queue between the parser and the result ports.
`timescale 1ns / 1ps
module mahs_queue import mahs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  hdr_word_t enq,
  input  logic      deq,
  output hdr_t      head,
  output logic      is_empty,
  output logic      is_full
);

  hdr_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_rd;

  assign is_empty = (count == '0);
  assign is_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head     = entries[rd_ptr];
  assign do_rd    = deq && !is_empty;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({enq.valid, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Header storage.
  always_ff @(posedge clk) begin
    if (enq.valid) begin
      entries[wr_ptr] <= enq.hdr;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    enq.valid |-> !is_full || do_rd)
    else $error("header written into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule
